// ===== sv/fbl_pkg.sv =====
// Shared definitions for the fallback budget ledger: status codes, register
// indexes, field widths and a small helper function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbl_pkg;

	// Field widths fixed by the item layout.
	localparam int unsigned REASON_W = 8;
	localparam int unsigned PC_W     = 64;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned BLK_W    = 32;
	localparam int unsigned INS_W    = 48;
	localparam int unsigned CFG_W    = 48;
	localparam int unsigned CFG_IDX_W = 2;

	// Default number of refusal reasons.
	localparam int unsigned REASONS_DEF = 8;

	// Input item: tdata = reason, refusal_pc, executed_pc, executed_count.
	localparam int unsigned S_DATA_W = 168;
	// Result item: tdata = status, next_limit, blocks_used, instructions_used.
	localparam int unsigned M_DATA_W = 120;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_BAD_REASON     = 3'd1,
		ST_BLOCKS_SPENT   = 3'd2,
		ST_INSNS_SPENT    = 3'd3,
		ST_PC_MISMATCH    = 3'd4,
		ST_ZERO_COUNT     = 3'd5,
		ST_PER_BLOCK_OVER = 3'd6,
		ST_TOTAL_OVER     = 3'd7
	} status_t;

	// Item kinds carried on tuser.
	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BUDGET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BUDGET    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_BLOCK_LIMIT = 2'd2;

	// Write to the per-reason counter store.
	typedef struct packed {
		logic             we;
		logic [BLK_W-1:0] blocks;
		logic [INS_W-1:0] insns;
	} rs_wr_t;

	// Block counters stop at all ones instead of wrapping.
	function automatic logic [BLK_W-1:0] sat_inc(input logic [BLK_W-1:0] v);
		sat_inc = (&v) ? v : v + BLK_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== sv/fbl_reason_store.sv =====
// Per-reason block and instruction counters for the fallback budget ledger.
// One write and one registered read per cycle; depends on fbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbl_reason_store #(
	parameter int unsigned REASONS = fbl_pkg::REASONS_DEF,
	parameter int unsigned IDX_W   = (REASONS > 1) ? $clog2(REASONS) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [IDX_W-1:0]         rd_idx,
	output logic      [fbl_pkg::BLK_W-1:0] rd_blocks,
	output logic      [fbl_pkg::INS_W-1:0] rd_insns,
	input  wire logic [IDX_W-1:0]         wr_idx,
	input  wire fbl_pkg::rs_wr_t          wr
);

	logic [fbl_pkg::BLK_W-1:0] blocks_mem [REASONS];
	logic [fbl_pkg::INS_W-1:0] insns_mem  [REASONS];
	logic [REASONS-1:0]        valid_q;

	// Entry valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Counter storage.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			blocks_mem[wr_idx] <= wr.blocks;
			insns_mem[wr_idx]  <= wr.insns;
		end
	end

	// Registered read; a write to the same entry in the same cycle is forwarded
	// so that back-to-back items of one reason see each other's update.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.we && (wr_idx == rd_idx)) begin
				rd_blocks <= wr.blocks;
				rd_insns  <= wr.insns;
			end else if (valid_q[rd_idx]) begin
				rd_blocks <= blocks_mem[rd_idx];
				rd_insns  <= insns_mem[rd_idx];
			end else begin
				rd_blocks <= '0;
				rd_insns  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/fbl_ledger.sv =====
// Budget registers, total counters and the per-item decision of the fallback
// budget ledger. Depends on fbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbl_ledger #(
	parameter int unsigned REASONS = fbl_pkg::REASONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fbl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fbl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          go,
	input  wire logic                          op,
	input  wire logic [fbl_pkg::REASON_W-1:0]  reason,
	input  wire logic [fbl_pkg::PC_W-1:0]      refusal_pc,
	input  wire logic [fbl_pkg::PC_W-1:0]      executed_pc,
	input  wire logic [fbl_pkg::CNT_W-1:0]     executed_count,
	input  wire logic [fbl_pkg::BLK_W-1:0]     rd_blocks,
	input  wire logic [fbl_pkg::INS_W-1:0]     rd_insns,
	output fbl_pkg::status_t                   status,
	output logic      [fbl_pkg::CNT_W-1:0]     next_limit,
	output logic      [fbl_pkg::BLK_W-1:0]     blocks_used,
	output logic      [fbl_pkg::INS_W-1:0]     instructions_used,
	output fbl_pkg::rs_wr_t                    wr
);

	logic [fbl_pkg::BLK_W-1:0] block_budget_q;
	logic [fbl_pkg::INS_W-1:0] total_budget_q;
	logic [fbl_pkg::CNT_W-1:0] per_block_limit_q;
	logic [fbl_pkg::BLK_W-1:0] block_count_q;
	logic [fbl_pkg::INS_W-1:0] insn_total_q;

	logic                      reason_ok;
	logic [fbl_pkg::INS_W:0]   total_sum;
	logic                      commit;
	logic [fbl_pkg::BLK_W-1:0] block_count_nx;
	logic [fbl_pkg::INS_W-1:0] insn_total_nx;
	logic [fbl_pkg::INS_W-1:0] remaining;

	// Configuration registers; writes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_budget_q    <= '0;
			total_budget_q    <= '0;
			per_block_limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbl_pkg::CFG_BLOCK_BUDGET:    block_budget_q    <= cfg_data[fbl_pkg::BLK_W-1:0];
				fbl_pkg::CFG_TOTAL_BUDGET:    total_budget_q    <= cfg_data;
				fbl_pkg::CFG_PER_BLOCK_LIMIT: per_block_limit_q <= cfg_data[fbl_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Decision, in the order the checks take priority.
	assign reason_ok = ({1'b0, reason} < (fbl_pkg::REASON_W + 1)'(REASONS));
	assign total_sum = {1'b0, insn_total_q} + (fbl_pkg::INS_W + 1)'(executed_count);

	always_comb begin
		priority if (!reason_ok) begin
			status = fbl_pkg::ST_BAD_REASON;
		end else if (op == fbl_pkg::OP_CHECK) begin
			priority if (block_count_q >= block_budget_q)
				status = fbl_pkg::ST_BLOCKS_SPENT;
			else if (insn_total_q >= total_budget_q)
				status = fbl_pkg::ST_INSNS_SPENT;
			else
				status = fbl_pkg::ST_OK;
		end else if (executed_pc != refusal_pc) begin
			status = fbl_pkg::ST_PC_MISMATCH;
		end else if (executed_count == '0) begin
			status = fbl_pkg::ST_ZERO_COUNT;
		end else if (executed_count > per_block_limit_q) begin
			status = fbl_pkg::ST_PER_BLOCK_OVER;
		end else if (total_sum > {1'b0, total_budget_q}) begin
			status = fbl_pkg::ST_TOTAL_OVER;
		end else begin
			status = fbl_pkg::ST_OK;
		end
	end

	// A record item that passes every check counts.
	assign commit = (op == fbl_pkg::OP_RECORD) && (status == fbl_pkg::ST_OK);

	assign block_count_nx = commit ? fbl_pkg::sat_inc(block_count_q) : block_count_q;
	assign insn_total_nx  = commit ? total_sum[fbl_pkg::INS_W-1:0] : insn_total_q;

	// Limit for the next block, taken after this item's update.
	assign remaining = total_budget_q - insn_total_nx;
	always_comb begin
		if (insn_total_nx >= total_budget_q) begin
			next_limit = '0;
		end else if ({16'b0, per_block_limit_q} < remaining) begin
			next_limit = per_block_limit_q;
		end else begin
			next_limit = remaining[fbl_pkg::CNT_W-1:0];
		end
	end

	assign blocks_used       = block_count_nx;
	assign instructions_used = insn_total_nx;

	// Per-reason update goes to the store.
	assign wr.we     = go && commit;
	assign wr.blocks = fbl_pkg::sat_inc(rd_blocks);
	assign wr.insns  = rd_insns + fbl_pkg::INS_W'(executed_count);

	// Total counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
			insn_total_q  <= '0;
		end else if (go) begin
			block_count_q <= block_count_nx;
			insn_total_q  <= insn_total_nx;
		end
	end

endmodule

`default_nettype wire

// ===== sv/fallback_budget_ledger.sv =====
// Top level of the fallback budget ledger: input stage, result register and
// the ledger and per-reason store. Depends on fbl_pkg, fbl_ledger, fbl_reason_store.
`timescale 1ns / 1ps
`default_nettype none

// The ledger takes one item per clock cycle while not stalled and returns one
// result item for each. An item is registered on entry (the per-reason store
// is read at the same time), and once the result register is free the ledger
// decides its status, updates the counters and loads the result register;
// throughput is set by that single update per cycle. The input stays ready
// while a result waits as long as the input stage is free or moving on. The
// user must write budgets through the configuration port only while no item
// is in flight (not enforced). All counters and budgets reset to zero.

module fallback_budget_ledger #(
	parameter int unsigned REASONS = fbl_pkg::REASONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write port.
	input  wire logic                          cfg_we,
	input  wire logic [fbl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fbl_pkg::CFG_W-1:0]     cfg_data,
	// Input items.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// reason[7:0], refusal_pc[71:8], executed_pc[135:72], executed_count[167:136]
	input  wire logic [fbl_pkg::S_DATA_W-1:0]  s_tdata,
	// op[0]
	input  wire logic                          s_tuser,
	// Result items.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// status[2:0], next_limit[34:3], blocks_used[66:35],
	// instructions_used[114:67], zero[119:115]
	output logic      [fbl_pkg::M_DATA_W-1:0]  m_tdata
);

	localparam int unsigned IDX_W = (REASONS > 1) ? $clog2(REASONS) : 1;

	logic                            valid_s1;
	logic                            op_s1;
	logic [fbl_pkg::REASON_W-1:0]    reason_s1;
	logic [fbl_pkg::PC_W-1:0]        rpc_s1;
	logic [fbl_pkg::PC_W-1:0]        epc_s1;
	logic [fbl_pkg::CNT_W-1:0]       cnt_s1;

	logic                            out_free;
	logic                            go;
	logic                            s_accept;
	logic [fbl_pkg::BLK_W-1:0]       rd_blocks;
	logic [fbl_pkg::INS_W-1:0]       rd_insns;
	fbl_pkg::rs_wr_t                 wr;
	fbl_pkg::status_t                status;
	logic [fbl_pkg::CNT_W-1:0]       next_limit;
	logic [fbl_pkg::BLK_W-1:0]       blocks_used;
	logic [fbl_pkg::INS_W-1:0]       instructions_used;
	logic                            out_valid_q;
	logic [fbl_pkg::M_DATA_W-1:0]    out_data_q;

	// Handshake: the stage moves on when the result register is free.
	assign out_free = !out_valid_q || m_tready;
	assign go       = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_accept = s_tvalid && s_tready;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1     <= s_tuser;
			reason_s1 <= s_tdata[7:0];
			rpc_s1    <= s_tdata[71:8];
			epc_s1    <= s_tdata[135:72];
			cnt_s1    <= s_tdata[167:136];
		end
	end

	fbl_reason_store #(
		.REASONS (REASONS),
		.IDX_W   (IDX_W)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (s_accept),
		.rd_idx    (s_tdata[IDX_W-1:0]),
		.rd_blocks (rd_blocks),
		.rd_insns  (rd_insns),
		.wr_idx    (reason_s1[IDX_W-1:0]),
		.wr        (wr)
	);

	fbl_ledger #(
		.REASONS (REASONS)
	) u_ledger (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.go                (go),
		.op                (op_s1),
		.reason            (reason_s1),
		.refusal_pc        (rpc_s1),
		.executed_pc       (epc_s1),
		.executed_count    (cnt_s1),
		.rd_blocks         (rd_blocks),
		.rd_insns          (rd_insns),
		.status            (status),
		.next_limit        (next_limit),
		.blocks_used       (blocks_used),
		.instructions_used (instructions_used),
		.wr                (wr)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_data_q <= {5'b0, instructions_used, blocks_used, next_limit, status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/fbl_checker.sv =====
// Port-level checks for the fallback budget ledger, bound to the top level.
// Depends on fallback_budget_ledger and fbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbl_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tvalid,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [fbl_pkg::M_DATA_W-1:0] m_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The input only stalls while a result waits at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// A result appearing on an idle output comes from an item taken via the input stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching input item");

	// Padding bits of the result are zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[fbl_pkg::M_DATA_W-1:115] == '0))
		else $error("result padding not zero");

endmodule

bind fallback_budget_ledger fbl_checker u_fbl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for fallback_budget_ledger: directed and random items,
// checked against a cycle-free model of the ledger. Depends on fbl_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned REASONS = fbl_pkg::REASONS_DEF;

	// One input item as the block sees it.
	typedef struct {
		logic             op;
		logic [7:0]       reason;
		logic [63:0]      refusal_pc;
		logic [63:0]      executed_pc;
		logic [31:0]      count;
	} ledger_req_t;

	// One result item.
	typedef struct {
		fbl_pkg::status_t status;
		logic [31:0]      next_limit;
		logic [31:0]      blocks;
		logic [47:0]      insns;
	} ledger_res_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [fbl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fbl_pkg::CFG_W-1:0]      cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [fbl_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [fbl_pkg::M_DATA_W-1:0]   m_tdata;

	fallback_budget_ledger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Ledger model: budgets, totals and per-reason counters.
	logic [31:0] cap_blocks = '0;
	logic [47:0] cap_insns = '0;
	logic [31:0] cap_per_block = '0;
	logic [31:0] led_blocks = '0;
	logic [47:0] led_insns = '0;
	logic [31:0] reason_blocks [REASONS];
	logic [47:0] reason_insns [REASONS];

	ledger_req_t req_queue [$];
	ledger_res_t results_due [$];
	int unsigned items_pushed = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;

	initial begin
		for (int i = 0; i < REASONS; i++) begin
			reason_blocks[i] = '0;
			reason_insns[i] = '0;
		end
	end

	function automatic logic [31:0] sat_bump(input logic [31:0] v);
		sat_bump = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Decide the status of one item, update the counters and form its result.
	task automatic ledger_apply(input ledger_req_t r, output ledger_res_t res);
		logic [48:0] sum;
		logic [47:0] remaining;
		sum = {1'b0, led_insns} + {17'd0, r.count};
		if (r.reason >= REASONS) begin
			res.status = fbl_pkg::ST_BAD_REASON;
		end else if (r.op == fbl_pkg::OP_CHECK) begin
			if (led_blocks >= cap_blocks)
				res.status = fbl_pkg::ST_BLOCKS_SPENT;
			else if (led_insns >= cap_insns)
				res.status = fbl_pkg::ST_INSNS_SPENT;
			else
				res.status = fbl_pkg::ST_OK;
		end else if (r.executed_pc != r.refusal_pc) begin
			res.status = fbl_pkg::ST_PC_MISMATCH;
		end else if (r.count == 32'd0) begin
			res.status = fbl_pkg::ST_ZERO_COUNT;
		end else if (r.count > cap_per_block) begin
			res.status = fbl_pkg::ST_PER_BLOCK_OVER;
		end else if (sum > {1'b0, cap_insns}) begin
			res.status = fbl_pkg::ST_TOTAL_OVER;
		end else begin
			res.status = fbl_pkg::ST_OK;
			led_blocks = sat_bump(led_blocks);
			led_insns = sum[47:0];
			reason_blocks[r.reason] = sat_bump(reason_blocks[r.reason]);
			reason_insns[r.reason] = reason_insns[r.reason] + {16'd0, r.count};
		end
		// The next block may use the smaller of the per-block limit and what is left.
		if (led_insns >= cap_insns) begin
			res.next_limit = '0;
		end else begin
			remaining = cap_insns - led_insns;
			res.next_limit = ({16'd0, cap_per_block} < remaining) ? cap_per_block
				: remaining[31:0];
		end
		res.blocks = led_blocks;
		res.insns = led_insns;
	endtask

	// Driver: sends queued items in bursts separated by random gaps.
	ledger_req_t on_bus;
	ledger_res_t predicted;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				ledger_apply(on_bus, predicted);
				results_due.push_back(predicted);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					on_bus = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_bus.op;
					s_tdata <= {on_bus.count, on_bus.executed_pc, on_bus.refusal_pc,
						on_bus.reason};
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern is chosen at random from four modes; results are checked in order.
	int unsigned rx_cycle = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	ledger_res_t oldest;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result item, expected none, actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					oldest = results_due.pop_front();
					if (m_tdata[2:0] != oldest.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							oldest.status, m_tdata[2:0]);
						mismatches++;
					end
					if (m_tdata[34:3] != oldest.next_limit) begin
						$display("%0t: next_limit expected %h actual %h", $time,
							oldest.next_limit, m_tdata[34:3]);
						mismatches++;
					end
					if (m_tdata[66:35] != oldest.blocks) begin
						$display("%0t: blocks_used expected %h actual %h", $time,
							oldest.blocks, m_tdata[66:35]);
						mismatches++;
					end
					if (m_tdata[114:67] != oldest.insns) begin
						$display("%0t: instructions_used expected %h actual %h", $time,
							oldest.insns, m_tdata[114:67]);
						mismatches++;
					end
					if (m_tdata[119:115] != 5'd0) begin
						$display("%0t: padding expected 0 actual %h", $time,
							m_tdata[119:115]);
						mismatches++;
					end
				end
			end
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_cycle % 7) >= 3;
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						m_tready <= 1'b0;
					end else if ($urandom_range(0, 19) == 0) begin
						stall_left = $urandom_range(4, 16);
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	task automatic queue_item(input logic op, input logic [7:0] reason,
			input logic [63:0] rpc, input logic [63:0] epc, input logic [31:0] count);
		ledger_req_t it;
		it.op = op;
		it.reason = reason;
		it.refusal_pc = rpc;
		it.executed_pc = epc;
		it.count = count;
		req_queue.push_back(it);
		items_pushed++;
	endtask

	// Wait until every queued item has produced its result.
	task automatic drain();
		while (results_seen != items_pushed)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fbl_pkg::CFG_IDX_W-1:0] idx,
			input logic [fbl_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fbl_pkg::CFG_BLOCK_BUDGET:    cap_blocks = val[31:0];
			fbl_pkg::CFG_TOTAL_BUDGET:    cap_insns = val[47:0];
			fbl_pkg::CFG_PER_BLOCK_LIMIT: cap_per_block = val[31:0];
			default: ;
		endcase
	endtask

	// Overall time limit.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Stimulus sequence.
	initial begin
		ledger_req_t it;
		logic [47:0] v_blocks;
		logic [47:0] v_total;
		logic [47:0] v_per;
		int unsigned k;
		int unsigned lo;
		logic [47:0] back;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// All budgets zero after reset.
		queue_item(fbl_pkg::OP_CHECK, 8'd0, 64'd0, 64'd0, 32'd0);
		queue_item(fbl_pkg::OP_RECORD, 8'd7, 64'd0, 64'd0, 32'd1);
		queue_item(fbl_pkg::OP_RECORD, 8'd2, 64'd5, 64'd5, 32'd0);
		queue_item(fbl_pkg::OP_RECORD, 8'd1, 64'd0, '1, 32'd3);
		queue_item(fbl_pkg::OP_CHECK, 8'(REASONS), 64'd0, 64'd0, 32'd0);
		queue_item(fbl_pkg::OP_RECORD, 8'hFF, '1, '1, '1);
		drain();

		// Small budgets; the upper bits of a 32-bit register write are dropped.
		write_reg(fbl_pkg::CFG_BLOCK_BUDGET, 48'hABCD_0000_0002);
		write_reg(fbl_pkg::CFG_TOTAL_BUDGET, 48'd100);
		write_reg(fbl_pkg::CFG_PER_BLOCK_LIMIT, 48'd60);
		queue_item(fbl_pkg::OP_CHECK, 8'd0, 64'd0, 64'd0, 32'd0);
		queue_item(fbl_pkg::OP_RECORD, 8'd3, 64'h1000, 64'h1000, 32'd61);
		queue_item(fbl_pkg::OP_RECORD, 8'd3, 64'h1000, 64'h1000, 32'd60);
		queue_item(fbl_pkg::OP_RECORD, 8'd4, 64'h2000, 64'h2000, 32'd41);
		queue_item(fbl_pkg::OP_RECORD, 8'd4, 64'h2000, 64'h2000, 32'd40);
		queue_item(fbl_pkg::OP_CHECK, 8'd5, 64'd0, 64'd0, 32'd0);
		drain();

		// Block budget no longer binding: instruction budget spent.
		write_reg(fbl_pkg::CFG_BLOCK_BUDGET, 48'h0000_FFFF_FFFF);
		queue_item(fbl_pkg::OP_CHECK, 8'd6, 64'd0, 64'd0, 32'd0);
		queue_item(fbl_pkg::OP_RECORD, 8'd6, 64'h30, 64'h30, 32'd1);
		drain();

		// Largest budgets and largest single count.
		write_reg(fbl_pkg::CFG_TOTAL_BUDGET, 48'hFFFF_FFFF_FFFF);
		write_reg(fbl_pkg::CFG_PER_BLOCK_LIMIT, 48'hFFFF_FFFF_FFFF);
		queue_item(fbl_pkg::OP_RECORD, 8'd7, '1, '1, '1);
		queue_item(fbl_pkg::OP_CHECK, 8'd7, '1, 64'd0, '1);
		queue_item(fbl_pkg::OP_RECORD, 8'd0, '1, '1, 32'd0);
		queue_item(fbl_pkg::OP_RECORD, 8'd1, 64'h5555_AAAA_5555_AAAA,
			64'h5555_AAAA_5555_AAAA, 32'h8000_0000);
		drain();

		// Random phases, each under its own budget setting.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					v_blocks = {16'($urandom), 32'(led_blocks + $urandom_range(1, 30))};
					v_total = led_insns + 48'($urandom_range(20, 3000));
					v_per = 48'($urandom_range(1, 300));
				end
				1: begin
					v_blocks = {16'($urandom), 32'($urandom)};
					v_total = led_insns + 48'($urandom);
					v_per = {16'($urandom), 32'($urandom)};
				end
				2: begin
					v_blocks = '0;
					v_total = '0;
					v_per = '0;
				end
				3: begin
					v_blocks = 48'(led_blocks + $urandom_range(5, 60));
					v_total = led_insns + 48'($urandom_range(1, 500));
					v_per = 48'($urandom_range(200, 2000));
				end
				4: begin
					v_blocks = '1;
					v_total = '1;
					v_per = '1;
				end
				default: begin
					// Total budget at or just below what has been used.
					v_blocks = 48'h0000_FFFF_FFFF;
					back = 48'($urandom_range(0, 100));
					v_total = (led_insns > back) ? led_insns - back : 48'd0;
					v_per = 48'($urandom_range(1, 1000));
				end
			endcase
			write_reg(fbl_pkg::CFG_PER_BLOCK_LIMIT, v_per);
			write_reg(fbl_pkg::CFG_BLOCK_BUDGET, v_blocks);
			write_reg(fbl_pkg::CFG_TOTAL_BUDGET, v_total);

			for (int n = 0; n < 240; n++) begin
				k = $urandom_range(0, 99);
				it.op = fbl_pkg::OP_RECORD;
				it.reason = 8'($urandom_range(0, REASONS - 1));
				it.refusal_pc = {$urandom, $urandom};
				it.executed_pc = it.refusal_pc;
				if (k < 60) begin
					// Record with a nonzero count; sometimes exactly at the per-block limit.
					if (cap_per_block == 32'd0)
						it.count = $urandom_range(1, 5);
					else if ($urandom_range(0, 9) == 0)
						it.count = cap_per_block;
					else
						it.count = $urandom_range(1, cap_per_block);
				end else if (k < 80) begin
					it.op = fbl_pkg::OP_CHECK;
					it.count = $urandom;
				end else if (k < 85) begin
					lo = $urandom_range(1, 3);
					it.count = cap_per_block + lo;
				end else if (k < 90) begin
					it.executed_pc = it.refusal_pc ^ (64'd1 << $urandom_range(0, 63));
					it.count = $urandom_range(1, 100);
				end else if (k < 93) begin
					it.count = '0;
				end else begin
					it.op = 1'($urandom_range(0, 1));
					it.reason = 8'($urandom_range(0, 255));
					it.executed_pc = {$urandom, $urandom};
					it.count = $urandom;
				end
				queue_item(it.op, it.reason, it.refusal_pc, it.executed_pc, it.count);
			end
			drain();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fbl_pkg.sv
sv/fbl_reason_store.sv
sv/fbl_ledger.sv
sv/fallback_budget_ledger.sv
sv/fbl_checker.sv
verif/tb.sv
